### hdl/lqrsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LQR state feedback torque unit: shared definitions
// Widths, gain table geometry, item types, register and column codes, and the
// command and status types that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lqrsf_pkg;

    localparam int STATE_W      = 16;
    localparam int GAIN_W       = 16;
    localparam int TORQUE_W     = 16;
    localparam int ROWS         = 4;
    localparam int COLS         = 12;
    localparam int GAIN_DEPTH   = ROWS * COLS;
    localparam int GAIN_AW      = $clog2(GAIN_DEPTH);
    localparam int ROW_W        = $clog2(ROWS);
    localparam int COL_W        = $clog2(COLS);
    localparam int SEL_W        = 6;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int LIMIT_W      = 15;
    localparam int TIME_W       = 16;
    localparam int TIME_FRAC    = 16;
    localparam int TORQUE_SHIFT = 12;
    localparam int LEG_ROW_FIRST = 2;

    // One shared signed multiplier covers a gain or a state value times a
    // state value, possibly negated, or an unsigned 16-bit register.
    localparam int MUL_W  = STATE_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + COL_W;

    // Register reset values.
    localparam logic signed [STATE_W-1:0] RST_PITCH_OFFSET = '0;
    localparam logic [LIMIT_W-1:0]        RST_PITCH_LIMIT  = LIMIT_W'(4096);
    localparam logic [LIMIT_W-1:0]        RST_DIST_LIMIT   = LIMIT_W'(4096);
    localparam logic [TIME_W-1:0]         RST_STEP_TIME    = TIME_W'(131);
    localparam logic [TIME_W-1:0]         RST_LEAN_GAIN    = TIME_W'(1311);

    // Item command codes.
    localparam logic CMD_STEP       = 1'b0;
    localparam logic CMD_GAIN_WRITE = 1'b1;

    // Mode flag positions within select during a control step.
    localparam int SEL_SPIN     = 0;
    localparam int SEL_UPSTAIRS = 1;
    localparam int SEL_GROUNDED = 2;

    // State vector columns.
    localparam logic [COL_W-1:0] COL_DIST        = COL_W'(0);
    localparam logic [COL_W-1:0] COL_SPEED       = COL_W'(1);
    localparam logic [COL_W-1:0] COL_YAW         = COL_W'(2);
    localparam logic [COL_W-1:0] COL_YAW_RATE    = COL_W'(3);
    localparam logic [COL_W-1:0] COL_LEFT_ANGLE  = COL_W'(4);
    localparam logic [COL_W-1:0] COL_LEFT_RATE   = COL_W'(5);
    localparam logic [COL_W-1:0] COL_RIGHT_ANGLE = COL_W'(6);
    localparam logic [COL_W-1:0] COL_RIGHT_RATE  = COL_W'(7);
    localparam logic [COL_W-1:0] COL_PITCH       = COL_W'(8);
    localparam logic [COL_W-1:0] COL_PITCH_RATE  = COL_W'(9);
    localparam logic [COL_W-1:0] COL_PITCH_INT   = COL_W'(10);
    localparam logic [COL_W-1:0] COL_DIST_INT    = COL_W'(11);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PITCH_OFFSET = CFG_IDX_W'(0),
        REG_PITCH_LIMIT  = CFG_IDX_W'(1),
        REG_DIST_LIMIT   = CFG_IDX_W'(2),
        REG_STEP_TIME    = CFG_IDX_W'(3),
        REG_LEAN_GAIN    = CFG_IDX_W'(4)
    } cfg_reg_e;

    typedef struct packed {
        logic                      cmd;
        logic [SEL_W-1:0]          select;
        logic signed [STATE_W-1:0] distance_or_gain;
        logic signed [STATE_W-1:0] fwd_speed_err;
        logic signed [STATE_W-1:0] yaw_angle_err;
        logic signed [STATE_W-1:0] yaw_rate;
        logic signed [STATE_W-1:0] left_leg_angle;
        logic signed [STATE_W-1:0] left_leg_rate;
        logic signed [STATE_W-1:0] right_leg_angle;
        logic signed [STATE_W-1:0] right_leg_rate;
        logic signed [STATE_W-1:0] pitch_angle;
        logic signed [STATE_W-1:0] pitch_rate;
    } in_item_t;

    typedef struct packed {
        logic signed [TORQUE_W-1:0] left_wheel_torque;
        logic signed [TORQUE_W-1:0] right_wheel_torque;
        logic signed [TORQUE_W-1:0] left_leg_torque;
        logic signed [TORQUE_W-1:0] right_leg_torque;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAN,
        ST_PITCH,
        ST_DIST,
        ST_LEGS,
        ST_MAC,
        ST_DRAIN,
        ST_DONE
    } ctrl_state_e;

    // Preparation phase of the datapath; PH_IDLE leaves the multiplier on the
    // gain products.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAN,
        PH_PITCH,
        PH_DIST,
        PH_LEGS
    } dp_phase_e;

    typedef struct packed {
        logic               load;
        logic               gain_we;
        dp_phase_e          phase;
        logic               mac_issue;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [GAIN_AW-1:0] addr;
        logic               out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic mac_done;
    } dp_status_t;

    // Saturate a widened difference to the signed state width.
    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [STATE_W+1:0] v
    );
        logic signed [STATE_W+1:0] vmax;
        logic signed [STATE_W+1:0] vmin;
        vmax = $signed({3'b000, {(STATE_W-1){1'b1}}});
        vmin = $signed({3'b111, {(STATE_W-1){1'b0}}});
        if (v > vmax) begin
            return vmax[STATE_W-1:0];
        end
        else if (v < vmin) begin
            return vmin[STATE_W-1:0];
        end
        return v[STATE_W-1:0];
    endfunction

    // Fixed sign pattern of the feedback law; yaw flips sign on the leg rows.
    function automatic logic term_negated(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic neg;
        neg = 1'b0;
        case (col) inside
            COL_YAW:
            begin
                neg = (row >= ROW_W'(LEG_ROW_FIRST));
            end
            COL_YAW_RATE, COL_LEFT_ANGLE, COL_LEFT_RATE, COL_RIGHT_ANGLE, COL_RIGHT_RATE:
            begin
                neg = 1'b1;
            end
            default:
            begin
                neg = 1'b0;
            end
        endcase
        return neg;
    endfunction

endpackage

### hdl/lqrsf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module lqrsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/lqrsf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LQR state feedback datapath
// Holds the registers, the gain RAM, the integrators and one shared
// multiplier that serves both the preparation steps and the gain products.
// ----------------------------------------------------------------------------
module lqrsf_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lqrsf_pkg::dp_cmd_t                  cmd,
    output lqrsf_pkg::dp_status_t               status,
    input  lqrsf_pkg::in_item_t                 in_data,
    input  logic                                cfg_we,
    input  logic [lqrsf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lqrsf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output lqrsf_pkg::out_item_t                out_data
);
    import lqrsf_pkg::*;

    localparam logic signed [ACC_W-1:0] TQ_MAX = ACC_W'((1 << (TORQUE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] TQ_MIN = ~TQ_MAX;

    // Configuration registers.
    logic signed [STATE_W-1:0] pitch_offset_reg;
    logic [LIMIT_W-1:0]        pitch_limit_reg;
    logic [LIMIT_W-1:0]        dist_limit_reg;
    logic [TIME_W-1:0]         step_time_reg;
    logic [TIME_W-1:0]         lean_gain_reg;

    // Step item and derived state terms.
    in_item_t                  item_reg;
    logic signed [STATE_W-1:0] perr_reg;
    logic signed [STATE_W-1:0] dist_reg;
    logic signed [STATE_W-1:0] lean_reg;
    logic signed [STATE_W-1:0] leg_l_reg;
    logic signed [STATE_W-1:0] leg_r_reg;
    logic signed [STATE_W-1:0] pint_reg;
    logic signed [STATE_W-1:0] dint_reg;

    // Product pipeline.
    logic signed [MUL_W-1:0]   op_reg;
    logic                      v1_reg;
    logic [ROW_W-1:0]          r1_reg;
    logic [COL_W-1:0]          c1_reg;
    logic                      v2_reg;
    logic [ROW_W-1:0]          r2_reg;
    logic [COL_W-1:0]          c2_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [TORQUE_W-1:0] torque_reg [ROWS];
    out_item_t                 out_data_reg;

    logic [GAIN_W-1:0]         gain_rdata;
    logic                      spinning;
    logic                      upstairs;
    logic                      grounded;
    logic signed [STATE_W+1:0] pitch_diff;
    logic signed [STATE_W+1:0] leg_l_diff;
    logic signed [STATE_W+1:0] leg_r_diff;
    logic signed [STATE_W-1:0] x_sel;
    logic signed [MUL_W-1:0]   op_next;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   acc_scaled;
    logic signed [TORQUE_W-1:0] torque_sat;

    // integral + floor(prod / 2^16), clamped to the symmetric limit.
    function automatic logic signed [STATE_W-1:0] integrate(
        input logic signed [STATE_W-1:0] acc,
        input logic signed [PROD_W-1:0]  prod,
        input logic [LIMIT_W-1:0]        limit
    );
        logic signed [STATE_W:0]   delta;
        logic signed [STATE_W+1:0] sum;
        logic signed [STATE_W+1:0] lim;
        delta = prod[TIME_FRAC +: STATE_W+1];
        sum   = (STATE_W+2)'(acc) + (STATE_W+2)'(delta);
        lim   = $signed((STATE_W+2)'(limit));
        if (sum > lim) begin
            sum = lim;
        end
        else if (sum < -lim) begin
            sum = -lim;
        end
        return sum[STATE_W-1:0];
    endfunction

    lqrsf_ram #(
        .WIDTH (GAIN_W),
        .DEPTH (GAIN_DEPTH)
    ) u_gain_ram (
        .clk   (clk),
        .we    (cmd.gain_we),
        .waddr (in_data.select[GAIN_AW-1:0]),
        .wdata (in_data.distance_or_gain[GAIN_W-1:0]),
        .raddr (cmd.addr),
        .rdata (gain_rdata)
    );

    assign spinning = item_reg.select[SEL_SPIN];
    assign upstairs = item_reg.select[SEL_UPSTAIRS];
    assign grounded = item_reg.select[SEL_GROUNDED];

    assign pitch_diff = (STATE_W+2)'(item_reg.pitch_angle) - (STATE_W+2)'(pitch_offset_reg);
    assign leg_l_diff = (STATE_W+2)'(item_reg.left_leg_angle) - (STATE_W+2)'(lean_reg);
    assign leg_r_diff = (STATE_W+2)'(item_reg.right_leg_angle) - (STATE_W+2)'(lean_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pitch_offset_reg <= RST_PITCH_OFFSET;
            pitch_limit_reg  <= RST_PITCH_LIMIT;
            dist_limit_reg   <= RST_DIST_LIMIT;
            step_time_reg    <= RST_STEP_TIME;
            lean_gain_reg    <= RST_LEAN_GAIN;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                REG_PITCH_OFFSET: pitch_offset_reg <= $signed(cfg_wdata[STATE_W-1:0]);
                REG_PITCH_LIMIT:  pitch_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                REG_DIST_LIMIT:   dist_limit_reg   <= cfg_wdata[LIMIT_W-1:0];
                REG_STEP_TIME:    step_time_reg    <= cfg_wdata[TIME_W-1:0];
                REG_LEAN_GAIN:    lean_gain_reg    <= cfg_wdata[TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The shared multiplier: preparation products first, then gain products.
    always_comb
    begin
        unique case (cmd.phase)
            PH_LEAN:
            begin
                mul_a = MUL_W'(item_reg.fwd_speed_err);
                mul_b = $signed(MUL_W'(lean_gain_reg));
            end
            PH_PITCH:
            begin
                mul_a = MUL_W'(perr_reg);
                mul_b = $signed(MUL_W'(step_time_reg));
            end
            PH_DIST:
            begin
                mul_a = MUL_W'(dist_reg);
                mul_b = $signed(MUL_W'(step_time_reg));
            end
            default:
            begin
                mul_a = MUL_W'($signed(gain_rdata));
                mul_b = op_reg;
            end
        endcase
    end

    // State vector column for the product being issued.
    always_comb
    begin
        case (cmd.col)
            COL_DIST:        x_sel = dist_reg;
            COL_SPEED:       x_sel = item_reg.fwd_speed_err;
            COL_YAW:
            begin
                x_sel = (spinning && cmd.row >= ROW_W'(LEG_ROW_FIRST)) ? '0
                                                                      : item_reg.yaw_angle_err;
            end
            COL_YAW_RATE:
            begin
                x_sel = (spinning && cmd.row >= ROW_W'(LEG_ROW_FIRST)) ? '0
                                                                      : item_reg.yaw_rate;
            end
            COL_LEFT_ANGLE:  x_sel = leg_l_reg;
            COL_LEFT_RATE:   x_sel = item_reg.left_leg_rate;
            COL_RIGHT_ANGLE: x_sel = leg_r_reg;
            COL_RIGHT_RATE:  x_sel = item_reg.right_leg_rate;
            COL_PITCH:       x_sel = perr_reg;
            COL_PITCH_RATE:  x_sel = item_reg.pitch_rate;
            COL_PITCH_INT:   x_sel = pint_reg;
            COL_DIST_INT:    x_sel = dint_reg;
            default:         x_sel = '0;
        endcase
        op_next = term_negated(cmd.row, cmd.col) ? -MUL_W'(x_sel) : MUL_W'(x_sel);
    end

    always_comb
    begin
        acc_sum    = ((c2_reg == COL_DIST) ? '0 : acc_reg) + ACC_W'(prod_reg);
        acc_scaled = acc_sum >>> TORQUE_SHIFT;
        if (acc_scaled > TQ_MAX) begin
            torque_sat = TQ_MAX[TORQUE_W-1:0];
        end
        else if (acc_scaled < TQ_MIN) begin
            torque_sat = TQ_MIN[TORQUE_W-1:0];
        end
        else begin
            torque_sat = acc_scaled[TORQUE_W-1:0];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            item_reg <= in_data;
        end
        prod_reg <= mul_a * mul_b;
        unique case (cmd.phase)
            PH_LEAN:
            begin
                perr_reg <= sat_state(pitch_diff);
                // Distance is zeroed while spinning or climbing stairs.
                dist_reg <= (spinning || upstairs) ? '0 : item_reg.distance_or_gain;
            end
            PH_PITCH:
            begin
                lean_reg <= spinning ? '0 : prod_reg[TIME_FRAC +: STATE_W];
            end
            PH_LEGS:
            begin
                leg_l_reg <= sat_state(leg_l_diff);
                leg_r_reg <= sat_state(leg_r_diff);
            end
            default:
            begin
            end
        endcase
        if (cmd.mac_issue) begin
            op_reg <= op_next;
            r1_reg <= cmd.row;
            c1_reg <= cmd.col;
        end
        r2_reg <= r1_reg;
        c2_reg <= c1_reg;
        if (v2_reg) begin
            acc_reg <= acc_sum;
            if (c2_reg == COL_DIST_INT) begin
                torque_reg[r2_reg] <= torque_sat;
            end
        end
        if (cmd.out_load) begin
            out_data_reg.left_wheel_torque  <= torque_reg[0];
            out_data_reg.right_wheel_torque <= torque_reg[1];
            out_data_reg.left_leg_torque    <= torque_reg[2];
            out_data_reg.right_leg_torque   <= torque_reg[3];
        end
    end

    // Integrators and pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pint_reg <= '0;
            dint_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end
        else begin
            if (grounded && cmd.phase == PH_DIST) begin
                pint_reg <= integrate(pint_reg, prod_reg, pitch_limit_reg);
            end
            if (grounded && cmd.phase == PH_LEGS) begin
                dint_reg <= integrate(dint_reg, prod_reg, dist_limit_reg);
            end
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
        end
    end

    assign status.mac_done = v2_reg && (r2_reg == ROW_W'(ROWS - 1)) && (c2_reg == COL_DIST_INT);
    assign out_data        = out_data_reg;

endmodule

### hdl/lqrsf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LQR state feedback controller
// Sequences preparation, the 48 gain products and the result hand-off, and
// owns both channel handshakes.
// ----------------------------------------------------------------------------
module lqrsf_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         in_cmd,
    input  logic [lqrsf_pkg::SEL_W-1:0]  in_select,
    output logic                         out_valid,
    input  logic                         out_stall,
    output lqrsf_pkg::dp_cmd_t           cmd,
    input  lqrsf_pkg::dp_status_t        status
);
    import lqrsf_pkg::*;

    ctrl_state_e        state_reg;
    ctrl_state_e        state_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [GAIN_AW-1:0] addr_reg;
    logic [GAIN_AW-1:0] addr_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.phase      = PH_IDLE;
        cmd.row        = row_reg;
        cmd.col        = col_reg;
        cmd.addr       = addr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    if (in_cmd == CMD_GAIN_WRITE) begin
                        // Indices past the table are dropped.
                        cmd.gain_we = (in_select < SEL_W'(GAIN_DEPTH));
                    end
                    else begin
                        cmd.load   = 1'b1;
                        state_next = ST_LEAN;
                    end
                end
            end
            ST_LEAN:
            begin
                cmd.phase  = PH_LEAN;
                state_next = ST_PITCH;
            end
            ST_PITCH:
            begin
                cmd.phase  = PH_PITCH;
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                cmd.phase  = PH_DIST;
                state_next = ST_LEGS;
            end
            ST_LEGS:
            begin
                cmd.phase  = PH_LEGS;
                row_next   = '0;
                col_next   = '0;
                addr_next  = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                addr_next     = addr_reg + GAIN_AW'(1);
                if (col_reg == COL_W'(COLS - 1)) begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end
                else begin
                    col_next = col_reg + COL_W'(1);
                end
                if (addr_reg == GAIN_AW'(GAIN_DEPTH - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.mac_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Wait here while the previous result is still held stalled.
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/lqr_state_feedback_torque_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LQR state feedback torque unit
// Wheel-leg balance controller with pitch and distance integral action.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_data) carries two kinds of
// transaction. A gain write (cmd set) loads one Q8.8 entry of the 4x12 gain
// table at index row*12+col and produces no result.
// A control step carries the measured errors and mode flags, updates the
// integrators when both legs are grounded and produces one result of four
// saturated Q8.8 torques on the output channel (out_valid, out_stall,
// out_data).
// From its acceptance to out_valid, a step runs the lean, pitch, distance and
// leg preparation steps on the shared multiplier, issues 48 gain products one
// per cycle to the same multiplier, drains the pipeline and hands off.
// The gain RAM read port and the single multiplier set a step's length; a new
// step is accepted in the cycle after the previous result is handed off.
// A finished result waits in the output register while a stalled receiver
// holds out_stall high; the next step is still accepted and computed, and it
// is held internally until that register frees up.
// Reset clears the integrators and restores the register defaults. The gain
// table is not cleared and must be written before the first step.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) are made while idle by the user; the block does not enforce this.
// ----------------------------------------------------------------------------
module lqr_state_feedback_torque_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  lqrsf_pkg::in_item_t                in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output lqrsf_pkg::out_item_t               out_data,
    input  logic                               cfg_we,
    input  logic [lqrsf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lqrsf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import lqrsf_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    lqrsf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_cmd    (in_data.cmd),
        .in_select (in_data.select),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    lqrsf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_data  (out_data)
    );

endmodule
